// ===== hw/rtl/nmea_rmc_position_parser_top_defines.svh =====
// Assertion macros used by the parser top module.
`ifndef NMEA_RMC_POSITION_PARSER_TOP_DEFINES_SVH
`define NMEA_RMC_POSITION_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NRP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("parser same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("parser next-cycle check failed");

`endif

// ===== hw/rtl/nmea_rmc_pkg.sv =====
`default_nettype none

package nmea_rmc_pkg;

   localparam int MAX_SENTENCE = 80;
   localparam int FRAC_DIGITS  = 5;

   localparam logic [31:0] MAG_LIMIT = 32'd1800000000;
   localparam logic [2:0]  HDR_IN_BODY = 3'd6;

   localparam logic [1:0] PH_INT  = 2'd0;
   localparam logic [1:0] PH_FRAC = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_A      = 8'h41;
   localparam logic [7:0] CH_C      = 8'h43;
   localparam logic [7:0] CH_E      = 8'h45;
   localparam logic [7:0] CH_G      = 8'h47;
   localparam logic [7:0] CH_M      = 8'h4D;
   localparam logic [7:0] CH_N      = 8'h4E;
   localparam logic [7:0] CH_P      = 8'h50;
   localparam logic [7:0] CH_R      = 8'h52;
   localparam logic [7:0] CH_NONE   = 8'h00;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } in_type;

   typedef struct packed {
      logic signed [31:0] latitude;
      logic signed [31:0] longitude;
      logic               fix_valid;
   } result_type;

   function automatic logic [7:0] header_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = CH_DOLLAR;
         3'd1:    ch = CH_G;
         3'd2:    ch = CH_P;
         3'd3:    ch = CH_R;
         3'd4:    ch = CH_M;
         3'd5:    ch = CH_C;
         default: ch = CH_NONE;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] expected_letter(input logic [3:0] field);
      logic [7:0] ch;
      unique case (field)
         4'd1:    ch = CH_A;
         4'd3:    ch = CH_N;
         4'd5:    ch = CH_E;
         default: ch = CH_NONE;
      endcase
      return ch;
   endfunction

   function automatic logic [19:0] pow10(input logic [2:0] n);
      logic [19:0] p;
      unique case (n)
         3'd0:    p = 20'd1;
         3'd1:    p = 20'd10;
         3'd2:    p = 20'd100;
         3'd3:    p = 20'd1000;
         3'd4:    p = 20'd10000;
         3'd5:    p = 20'd100000;
         3'd6:    p = 20'd1000000;
         default: p = 20'd1;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nmea_rmc_in_stage.sv =====
`default_nettype none

module nmea_rmc_in_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_rx_byte,
   input  wire logic                take,
   output nmea_rmc_pkg::in_type     in_q
);

   logic       vld_ff;
   logic       vld_in;
   logic [7:0] byte_ff;

   // hold the byte until the parser takes it
   assign req_stall = vld_ff && !take;
   assign vld_in    = req_stall ? vld_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign in_q.valid   = vld_ff;
   assign in_q.rx_byte = byte_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/nmea_rmc_core.sv =====
`default_nettype none

module nmea_rmc_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire nmea_rmc_pkg::in_type   in_q,
   input  wire logic                   out_free,
   output logic                        take,
   output logic                        emit,
   output nmea_rmc_pkg::result_type    result
);

   logic [2:0]  hdr_ff,       hdr_in;
   logic [6:0]  cnt_ff,       cnt_in;
   logic [3:0]  fld_ff,       fld_in;
   logic        tok_ne_ff,    tok_ne_in;
   logic        match_ff,     match_in;
   logic        status_ff,    status_in;
   logic [31:0] accum_ff,     accum_in;
   logic [2:0]  frac_ff,      frac_in;
   logic [1:0]  phase_ff,     phase_in;
   logic [31:0] lat_mag_ff,   lat_mag_in;
   logic [31:0] lon_mag_ff,   lon_mag_in;
   logic        lat_neg_ff,   lat_neg_in;
   logic        lon_neg_ff,   lon_neg_in;
   logic [31:0] cur_lat_ff,   cur_lat_in;
   logic [31:0] cur_lon_ff,   cur_lon_in;

   logic [7:0]  ch;
   logic        in_body;
   logic        too_long;
   logic        is_digit;
   logic [3:0]  digit;
   logic        star_req;

   logic [31:0] nv_acc;
   logic [2:0]  fc_clamp;
   logic [2:0]  nv_exp;
   logic [51:0] nv_prod;
   logic [31:0] nv;

   logic [31:0] a_acc;
   logic [2:0]  a_fc;
   logic [1:0]  a_ph;
   logic [31:0] a_dv;
   logic        fin_match;
   logic [7:0]  exp_ch;

   function automatic logic [31:0] acc_digit(input logic [31:0] a, input logic [3:0] d);
      logic [35:0] v;
      v = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {32'd0, d};
      if (v > {4'd0, nmea_rmc_pkg::MAG_LIMIT}) begin
         return nmea_rmc_pkg::MAG_LIMIT;
      end
      return v[31:0];
   endfunction

   assign ch       = in_q.rx_byte;
   assign in_body  = (hdr_ff == nmea_rmc_pkg::HDR_IN_BODY);
   assign too_long = (cnt_ff >= 7'(nmea_rmc_pkg::MAX_SENTENCE));
   assign is_digit = (ch >= nmea_rmc_pkg::CH_ZERO) && (ch <= nmea_rmc_pkg::CH_NINE);
   assign digit    = 4'(ch - nmea_rmc_pkg::CH_ZERO);
   assign star_req = in_q.valid && in_body && !too_long && (ch == nmea_rmc_pkg::CH_STAR);

   // a byte that ends a sentence waits for a free result slot
   assign take = in_q.valid && (!star_req || out_free);
   assign emit = take && star_req;

   // value of the token being closed; an empty token counts as zero
   assign nv_acc   = tok_ne_ff ? accum_ff : '0;
   assign fc_clamp = (frac_ff > 3'(nmea_rmc_pkg::FRAC_DIGITS)) ?
                     3'(nmea_rmc_pkg::FRAC_DIGITS) : frac_ff;
   assign nv_exp   = 3'(nmea_rmc_pkg::FRAC_DIGITS) - fc_clamp;
   assign nv_prod  = 52'(nv_acc) * 52'(nmea_rmc_pkg::pow10(nv_exp));
   assign nv       = (nv_prod > 52'(nmea_rmc_pkg::MAG_LIMIT)) ?
                     nmea_rmc_pkg::MAG_LIMIT : nv_prod[31:0];

   assign exp_ch = nmea_rmc_pkg::expected_letter(fld_ff);
   assign a_acc  = tok_ne_ff ? accum_ff : '0;
   assign a_fc   = tok_ne_ff ? frac_ff : '0;
   assign a_ph   = tok_ne_ff ? phase_ff : nmea_rmc_pkg::PH_INT;
   assign a_dv   = acc_digit(a_acc, digit);

   // a star always closes a token that does not match a single letter
   assign fin_match = (ch == nmea_rmc_pkg::CH_STAR) ? 1'b0 : match_ff;

   always_comb begin
      hdr_in     = hdr_ff;
      cnt_in     = cnt_ff;
      fld_in     = fld_ff;
      tok_ne_in  = tok_ne_ff;
      match_in   = match_ff;
      status_in  = status_ff;
      accum_in   = accum_ff;
      frac_in    = frac_ff;
      phase_in   = phase_ff;
      lat_mag_in = lat_mag_ff;
      lon_mag_in = lon_mag_ff;
      lat_neg_in = lat_neg_ff;
      lon_neg_in = lon_neg_ff;
      cur_lat_in = cur_lat_ff;
      cur_lon_in = cur_lon_ff;

      if (take) begin
         if (!in_body) begin
            if (ch == nmea_rmc_pkg::header_char(hdr_ff)) begin
               hdr_in = hdr_ff + 3'd1;
               if (hdr_in == nmea_rmc_pkg::HDR_IN_BODY) begin
                  cnt_in     = '0;
                  fld_in     = '0;
                  tok_ne_in  = 1'b0;
                  match_in   = 1'b0;
                  status_in  = 1'b0;
                  accum_in   = '0;
                  frac_in    = '0;
                  phase_in   = nmea_rmc_pkg::PH_INT;
                  lat_mag_in = '0;
                  lon_mag_in = '0;
                  lat_neg_in = 1'b1;
                  lon_neg_in = 1'b1;
               end
            end else begin
               hdr_in = (ch == nmea_rmc_pkg::CH_DOLLAR) ? 3'd1 : 3'd0;
            end
         end else if (too_long) begin
            // abandon and recheck this byte as the start of a header
            hdr_in = (ch == nmea_rmc_pkg::CH_DOLLAR) ? 3'd1 : 3'd0;
         end else begin
            cnt_in = cnt_ff + 7'd1;
            if (ch != nmea_rmc_pkg::CH_COMMA) begin
               // add the byte to the current token
               tok_ne_in = 1'b1;
               match_in  = !tok_ne_ff && (exp_ch != nmea_rmc_pkg::CH_NONE) && (ch == exp_ch);
               accum_in  = a_acc;
               frac_in   = a_fc;
               phase_in  = a_ph;
               case (a_ph)
                  nmea_rmc_pkg::PH_INT: begin
                     if (is_digit) begin
                        accum_in = a_dv;
                     end else if (ch == nmea_rmc_pkg::CH_DOT) begin
                        phase_in = nmea_rmc_pkg::PH_FRAC;
                     end else begin
                        phase_in = nmea_rmc_pkg::PH_DONE;
                     end
                  end
                  nmea_rmc_pkg::PH_FRAC: begin
                     if (is_digit) begin
                        if (a_fc < 3'(nmea_rmc_pkg::FRAC_DIGITS)) begin
                           accum_in = a_dv;
                           frac_in  = a_fc + 3'd1;
                        end
                     end else begin
                        phase_in = nmea_rmc_pkg::PH_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end

            // close the token on a comma after text, or on the star
            if ((ch == nmea_rmc_pkg::CH_COMMA && tok_ne_ff) ||
                ch == nmea_rmc_pkg::CH_STAR) begin
               case (fld_ff)
                  4'd1:    status_in  = fin_match;
                  4'd2:    lat_mag_in = nv;
                  4'd3:    lat_neg_in = !fin_match;
                  4'd4:    lon_mag_in = nv;
                  4'd5:    lon_neg_in = !fin_match;
                  default: begin
                  end
               endcase
               if (fld_ff != 4'd15) begin
                  fld_in = fld_ff + 4'd1;
               end
               tok_ne_in = 1'b0;
               match_in  = 1'b0;
            end

            if (ch == nmea_rmc_pkg::CH_STAR) begin
               if (status_in) begin
                  cur_lat_in = lat_neg_in ? (32'd0 - lat_mag_in) : lat_mag_in;
                  cur_lon_in = lon_neg_in ? (32'd0 - lon_mag_in) : lon_mag_in;
               end
               hdr_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff     <= '0;
         cnt_ff     <= '0;
         fld_ff     <= '0;
         tok_ne_ff  <= 1'b0;
         match_ff   <= 1'b0;
         status_ff  <= 1'b0;
         accum_ff   <= '0;
         frac_ff    <= '0;
         phase_ff   <= nmea_rmc_pkg::PH_INT;
         lat_mag_ff <= '0;
         lon_mag_ff <= '0;
         lat_neg_ff <= 1'b1;
         lon_neg_ff <= 1'b1;
         cur_lat_ff <= '0;
         cur_lon_ff <= '0;
      end else begin
         hdr_ff     <= hdr_in;
         cnt_ff     <= cnt_in;
         fld_ff     <= fld_in;
         tok_ne_ff  <= tok_ne_in;
         match_ff   <= match_in;
         status_ff  <= status_in;
         accum_ff   <= accum_in;
         frac_ff    <= frac_in;
         phase_ff   <= phase_in;
         lat_mag_ff <= lat_mag_in;
         lon_mag_ff <= lon_mag_in;
         lat_neg_ff <= lat_neg_in;
         lon_neg_ff <= lon_neg_in;
         cur_lat_ff <= cur_lat_in;
         cur_lon_ff <= cur_lon_in;
      end
   end

   assign result.latitude  = cur_lat_in;
   assign result.longitude = cur_lon_in;
   assign result.fix_valid = status_in;

endmodule

`default_nettype wire

// ===== hw/rtl/nmea_rmc_out_stage.sv =====
`default_nettype none

module nmea_rmc_out_stage (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       emit,
   input  wire nmea_rmc_pkg::result_type   result,
   output logic                            out_free,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [31:0]              rsp_latitude,
   output logic signed [31:0]              rsp_longitude,
   output logic                            rsp_fix_valid
);

   logic                     vld_ff;
   logic                     vld_in;
   nmea_rmc_pkg::result_type res_ff;

   assign out_free = !vld_ff || !rsp_stall;
   // load on a new result, drop once taken
   assign vld_in   = emit ? 1'b1 : (vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         res_ff <= result;
      end
   end

   assign rsp_valid     = vld_ff;
   assign rsp_latitude  = res_ff.latitude;
   assign rsp_longitude = res_ff.longitude;
   assign rsp_fix_valid = res_ff.fix_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/nmea_rmc_position_parser_top.sv =====
`default_nettype none
`include "nmea_rmc_position_parser_top_defines.svh"

// Position parser for NMEA RMC sentences: feed the received stream one byte per
// request; at each '*' that closes a "$GPRMC" sentence one response carries the
// held latitude and longitude (raw ddmm.mmmmm times 10^5, negative for south or
// west) and fix_valid, set when the status field was A and the position was
// updated. Throughput is one byte per clock while no '*' waits: each byte is
// registered, parsed by header match, token and decimal logic into the parse
// registers; a response lands in the result register in the cycle after its
// '*' is accepted. Only a '*' byte waits, and only while the result register
// holds a response that is stalled.
module nmea_rmc_position_parser_top (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_rx_byte,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [31:0]       rsp_latitude,
   output logic signed [31:0]       rsp_longitude,
   output logic                     rsp_fix_valid
);

   nmea_rmc_pkg::in_type     in_q;
   nmea_rmc_pkg::result_type core_result;
   logic                     take;
   logic                     core_emit;
   logic                     out_free;

   nmea_rmc_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .take        (take),
      .in_q        (in_q)
   );

   nmea_rmc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .in_q     (in_q),
      .out_free (out_free),
      .take     (take),
      .emit     (core_emit),
      .result   (core_result)
   );

   nmea_rmc_out_stage u_out (
      .clock         (clock),
      .reset         (reset),
      .emit          (core_emit),
      .result        (core_result),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_latitude  (rsp_latitude),
      .rsp_longitude (rsp_longitude),
      .rsp_fix_valid (rsp_fix_valid)
   );

   `NRP_ASSERT_NOW(a_emit_slot_free, clock, reset, core_emit, (!rsp_valid || !rsp_stall))
   `NRP_ASSERT_NEXT(a_emit_shows, clock, reset, core_emit, rsp_valid)
   `NRP_ASSERT_NOW(a_stall_has_byte, clock, reset, req_stall, in_q.valid)
   `NRP_ASSERT_NEXT(a_taken_clears, clock, reset, (rsp_valid && !rsp_stall && !core_emit), !rsp_valid)

endmodule

`default_nettype wire
